/* sv/lpda_pkg.sv */
// Shared widths, command and status codes, and control structs of the device allocator.
package lpda_pkg;

  localparam int MaxDevicesDefault = 8;
  localparam int FracBitsDefault   = 16;

  localparam int CMD_W     = 2;
  localparam int ID_W      = 4;
  localparam int MASK_W    = 9;
  localparam int COMPUTE_W = 32;
  localparam int MEMORY_W  = 40;
  localparam int SESS_W    = 8;
  localparam int LINK_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int LANES     = 5;
  localparam int LANE_W    = 40;

  localparam int LANE_COMPUTE = 0;
  localparam int LANE_MEMORY  = 1;
  localparam int LANE_DECODER = 2;
  localparam int LANE_ENCODER = 3;
  localparam int LANE_LINK    = 4;

  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;
  // The fourth code does nothing and answers done.
  localparam logic [CMD_W-1:0] CMD_IGNORED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADID   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic begin_rsv;
    logic div;
    logic first;
    logic cmp;
    logic apply;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fit;
    logic             empty;
    logic             last;
  } dp_stat_t;

  // Largest value a lane may hold; reservations saturate there.
  function automatic logic [LANE_W-1:0] lane_max(input int k);
    logic [LANE_W-1:0] m;
    case (k)
      LANE_COMPUTE: m = LANE_W'({COMPUTE_W{1'b1}});
      LANE_MEMORY:  m = LANE_W'({MEMORY_W{1'b1}});
      LANE_DECODER: m = LANE_W'({SESS_W{1'b1}});
      LANE_ENCODER: m = LANE_W'({SESS_W{1'b1}});
      default:      m = LANE_W'({LINK_W{1'b1}});
    endcase
    return m;
  endfunction

endpackage

/* sv/least_pressure_device_allocator.sv */
// Top level of the least-pressure device allocator: controller plus datapath.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_ready_o | cmd, device_id, cap_mask, five amounts
//   out     | output    | out_valid_o/out_ready_i | status, chosen_device
//
// Register, release and unknown commands pass through a dispatch state, where the result is
// registered, and a finish state that loads it into the output register. A reserve loads
// each device in turn; a fitting device then runs five restoring dividers that produce one
// quotient bit per cycle and a compare step, and an apply step updates the best device.
// Reset clears the controller, the device count, the seal and the found flag; the table is
// undefined until a device registers. A new transfer is taken while the previous result waits
// in the output register; a finished item then waits for that register to empty.
module least_pressure_device_allocator #(
  parameter int MAX_DEVICES        = lpda_pkg::MaxDevicesDefault,
  parameter int PRESSURE_FRAC_BITS = lpda_pkg::FracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lpda_pkg::CMD_W-1:0]     cmd_i,
  input  logic [lpda_pkg::ID_W-1:0]      device_id_i,
  input  logic [lpda_pkg::MASK_W-1:0]    cap_mask_i,
  input  logic [lpda_pkg::COMPUTE_W-1:0] compute_amount_i,
  input  logic [lpda_pkg::MEMORY_W-1:0]  memory_bytes_i,
  input  logic [lpda_pkg::SESS_W-1:0]    decoder_sessions_i,
  input  logic [lpda_pkg::SESS_W-1:0]    encoder_sessions_i,
  input  logic [lpda_pkg::LINK_W-1:0]    link_bandwidth_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lpda_pkg::STATUS_W-1:0]  status_o,
  output logic [lpda_pkg::ID_W-1:0]      chosen_device_o
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  // The controller walks the table by index and tells the datapath which
  // step to take; the datapath reports fit and end-of-table back.
  lpda_pkg::dp_cmd_t  dp_cmd;
  lpda_pkg::dp_stat_t dp_stat;
  logic [IDX_W-1:0]   scan_idx;

  lpda_ctrl #(
    .MAX_DEVICES        (MAX_DEVICES),
    .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .idx_o       (scan_idx)
  );

  // The datapath holds the table, the latched transfer and the result registers.
  lpda_dp #(
    .MAX_DEVICES        (MAX_DEVICES),
    .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .idx_i              (scan_idx),
    .stat_o             (dp_stat),
    .item_cmd_i         (cmd_i),
    .device_id_i        (device_id_i),
    .cap_mask_i         (cap_mask_i),
    .compute_amount_i   (compute_amount_i),
    .memory_bytes_i     (memory_bytes_i),
    .decoder_sessions_i (decoder_sessions_i),
    .encoder_sessions_i (encoder_sessions_i),
    .link_bandwidth_i   (link_bandwidth_i),
    .status_o           (status_o),
    .chosen_device_o    (chosen_device_o)
  );

endmodule

/* sv/lpda_ctrl.sv */
// Controller state machine of the device allocator: sequencing, scan index and divide count.
module lpda_ctrl #(
  parameter int MAX_DEVICES        = lpda_pkg::MaxDevicesDefault,
  parameter int PRESSURE_FRAC_BITS = lpda_pkg::FracBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lpda_pkg::dp_stat_t     stat_i,
  output lpda_pkg::dp_cmd_t      cmd_o,
  output logic [((MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1)-1:0] idx_o
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int BC_W  = $clog2(PRESSURE_FRAC_BITS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_LOAD     = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_CMP      = 3'd4;
  localparam logic [2:0] S_APPLY    = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [BC_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign idx_o       = idx_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bit_cnt_d   = bit_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.first = (bit_cnt_q == '0);
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = accept;
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.cmd == lpda_pkg::CMD_RESERVE) begin
          cmd_o.begin_rsv = 1'b1;
          idx_d           = '0;
          state_d         = stat_i.empty ? S_APPLY : S_LOAD;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_LOAD: begin
        bit_cnt_d = '0;
        if (stat_i.fit) begin
          state_d = S_DIV;
        end else if (stat_i.last) begin
          state_d = S_APPLY;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        bit_cnt_d = bit_cnt_q + BC_W'(1);
        if (bit_cnt_q == BC_W'(PRESSURE_FRAC_BITS)) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.last) begin
          state_d = S_APPLY;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_LOAD;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> bit_cnt_q <= BC_W'(PRESSURE_FRAC_BITS))
    else $error("divide counter ran past the last quotient bit");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result dropped before transfer");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISPATCH)
    else $error("accepted item not dispatched");

endmodule

/* sv/lpda_dp.sv */
// Datapath of the device allocator: device table, pressure dividers and best-device tracking.
module lpda_dp #(
  parameter int MAX_DEVICES        = lpda_pkg::MaxDevicesDefault,
  parameter int PRESSURE_FRAC_BITS = lpda_pkg::FracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpda_pkg::dp_cmd_t                   cmd_i,
  input  logic [((MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1)-1:0] idx_i,
  output lpda_pkg::dp_stat_t                  stat_o,
  input  logic [lpda_pkg::CMD_W-1:0]          item_cmd_i,
  input  logic [lpda_pkg::ID_W-1:0]           device_id_i,
  input  logic [lpda_pkg::MASK_W-1:0]         cap_mask_i,
  input  logic [lpda_pkg::COMPUTE_W-1:0]      compute_amount_i,
  input  logic [lpda_pkg::MEMORY_W-1:0]       memory_bytes_i,
  input  logic [lpda_pkg::SESS_W-1:0]         decoder_sessions_i,
  input  logic [lpda_pkg::SESS_W-1:0]         encoder_sessions_i,
  input  logic [lpda_pkg::LINK_W-1:0]         link_bandwidth_i,
  output logic [lpda_pkg::STATUS_W-1:0]       status_o,
  output logic [lpda_pkg::ID_W-1:0]           chosen_device_o
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam int Q_W   = PRESSURE_FRAC_BITS + 1;
  localparam int SUM_W = Q_W + 3;
  localparam int LW    = lpda_pkg::LANE_W;
  localparam int NL    = lpda_pkg::LANES;

  // Latched item.
  logic [lpda_pkg::CMD_W-1:0]  cmd_q;
  logic [lpda_pkg::ID_W-1:0]   id_q;
  logic [lpda_pkg::MASK_W-1:0] mask_q;
  logic [LW-1:0]               req_q [NL];

  // Device table.
  logic [lpda_pkg::MASK_W-1:0]    caps_q  [MAX_DEVICES];
  logic [lpda_pkg::COMPUTE_W-1:0] cap_c_q [MAX_DEVICES];
  logic [lpda_pkg::MEMORY_W-1:0]  cap_m_q [MAX_DEVICES];
  logic [lpda_pkg::SESS_W-1:0]    cap_d_q [MAX_DEVICES];
  logic [lpda_pkg::SESS_W-1:0]    cap_e_q [MAX_DEVICES];
  logic [lpda_pkg::LINK_W-1:0]    cap_l_q [MAX_DEVICES];
  logic [lpda_pkg::COMPUTE_W-1:0] res_c_q [MAX_DEVICES];
  logic [lpda_pkg::MEMORY_W-1:0]  res_m_q [MAX_DEVICES];
  logic [lpda_pkg::SESS_W-1:0]    res_d_q [MAX_DEVICES];
  logic [lpda_pkg::SESS_W-1:0]    res_e_q [MAX_DEVICES];
  logic [lpda_pkg::LINK_W-1:0]    res_l_q [MAX_DEVICES];

  logic [CNT_W-1:0] count_q;
  logic             sealed_q;
  logic             found_q;
  logic [IDX_W-1:0] best_q;
  logic [Q_W-1:0]   best_peak_q;
  logic [SUM_W-1:0] best_sum_q;
  logic [LW-1:0]    rem_q [NL];
  logic [Q_W-1:0]   quo_q [NL];

  logic [lpda_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [lpda_pkg::ID_W-1:0]     res_dev_q, out_dev_q;

  logic [IDX_W-1:0] addr;
  logic [LW-1:0]    cap_l  [NL];
  logic [LW-1:0]    have_l [NL];
  logic [LW:0]      sum_l  [NL];
  logic [LW-1:0]    add_l  [NL];
  logic [LW-1:0]    sub_l  [NL];
  logic [LW:0]      trial  [NL];
  logic             qbit   [NL];
  logic [LW-1:0]    rem_d  [NL];
  logic [LW-1:0]    res_wd [NL];
  logic             fit, refuse, id_ok, res_we, reg_we, better;
  logic [Q_W-1:0]   peak;
  logic [SUM_W-1:0] psum;

  assign refuse = sealed_q || (count_q >= CNT_W'(MAX_DEVICES));
  assign id_ok  = (32'(id_q) < 32'(count_q));

  always_comb begin
    if (cmd_i.apply) begin
      addr = best_q;
    end else if (cmd_i.exec && cmd_q == lpda_pkg::CMD_RELEASE) begin
      addr = id_q[IDX_W-1:0];
    end else if (cmd_i.exec) begin
      addr = count_q[IDX_W-1:0];
    end else begin
      addr = idx_i;
    end
  end

  always_comb begin
    cap_l[lpda_pkg::LANE_COMPUTE]  = LW'(cap_c_q[addr]);
    cap_l[lpda_pkg::LANE_MEMORY]   = LW'(cap_m_q[addr]);
    cap_l[lpda_pkg::LANE_DECODER]  = LW'(cap_d_q[addr]);
    cap_l[lpda_pkg::LANE_ENCODER]  = LW'(cap_e_q[addr]);
    cap_l[lpda_pkg::LANE_LINK]     = LW'(cap_l_q[addr]);
    have_l[lpda_pkg::LANE_COMPUTE] = LW'(res_c_q[addr]);
    have_l[lpda_pkg::LANE_MEMORY]  = LW'(res_m_q[addr]);
    have_l[lpda_pkg::LANE_DECODER] = LW'(res_d_q[addr]);
    have_l[lpda_pkg::LANE_ENCODER] = LW'(res_e_q[addr]);
    have_l[lpda_pkg::LANE_LINK]    = LW'(res_l_q[addr]);
  end

  // Per-lane sum, fit check, saturating add and subtract, one restoring divide step, and peak and sum of quotients.
  always_comb begin
    fit  = ((mask_q & ~caps_q[addr]) == '0);
    peak = '0;
    psum = '0;
    for (int k = 0; k < NL; k++) begin
      sum_l[k] = {1'b0, have_l[k]} + {1'b0, req_q[k]};
      if (cap_l[k] != '0 && sum_l[k] > {1'b0, cap_l[k]}) begin
        fit = 1'b0;
      end
      add_l[k] = (sum_l[k] > {1'b0, lpda_pkg::lane_max(k)}) ? lpda_pkg::lane_max(k)
                                                          : sum_l[k][LW-1:0];
      sub_l[k] = (have_l[k] >= req_q[k]) ? (have_l[k] - req_q[k]) : '0;
      trial[k] = cmd_i.first ? sum_l[k] : {rem_q[k], 1'b0};
      qbit[k]  = (cap_l[k] != '0) && (trial[k] >= {1'b0, cap_l[k]});
      rem_d[k] = qbit[k] ? LW'(trial[k] - {1'b0, cap_l[k]}) : trial[k][LW-1:0];
      if (quo_q[k] > peak) begin
        peak = quo_q[k];
      end
      psum = psum + SUM_W'(quo_q[k]);
    end
  end

  assign better = !found_q || (peak < best_peak_q) ||
                  ((peak == best_peak_q) && (psum < best_sum_q));

  always_comb begin
    reg_we = cmd_i.exec && (cmd_q == lpda_pkg::CMD_REGISTER) && !refuse;
    res_we = reg_we || (cmd_i.exec && (cmd_q == lpda_pkg::CMD_RELEASE) && id_ok) ||
             (cmd_i.apply && found_q);
    for (int k = 0; k < NL; k++) begin
      if (reg_we) begin
        res_wd[k] = '0;
      end else if (cmd_i.apply) begin
        res_wd[k] = add_l[k];
      end else begin
        res_wd[k] = sub_l[k];
      end
    end
  end

  // Table, latched item, dividers, best device and results: payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= item_cmd_i;
      id_q   <= device_id_i;
      mask_q <= cap_mask_i;
      req_q[lpda_pkg::LANE_COMPUTE] <= LW'(compute_amount_i);
      req_q[lpda_pkg::LANE_MEMORY]  <= LW'(memory_bytes_i);
      req_q[lpda_pkg::LANE_DECODER] <= LW'(decoder_sessions_i);
      req_q[lpda_pkg::LANE_ENCODER] <= LW'(encoder_sessions_i);
      req_q[lpda_pkg::LANE_LINK]    <= LW'(link_bandwidth_i);
    end
    if (reg_we) begin
      caps_q[addr]  <= mask_q;
      cap_c_q[addr] <= req_q[lpda_pkg::LANE_COMPUTE][lpda_pkg::COMPUTE_W-1:0];
      cap_m_q[addr] <= req_q[lpda_pkg::LANE_MEMORY][lpda_pkg::MEMORY_W-1:0];
      cap_d_q[addr] <= req_q[lpda_pkg::LANE_DECODER][lpda_pkg::SESS_W-1:0];
      cap_e_q[addr] <= req_q[lpda_pkg::LANE_ENCODER][lpda_pkg::SESS_W-1:0];
      cap_l_q[addr] <= req_q[lpda_pkg::LANE_LINK][lpda_pkg::LINK_W-1:0];
    end
    if (res_we) begin
      res_c_q[addr] <= res_wd[lpda_pkg::LANE_COMPUTE][lpda_pkg::COMPUTE_W-1:0];
      res_m_q[addr] <= res_wd[lpda_pkg::LANE_MEMORY][lpda_pkg::MEMORY_W-1:0];
      res_d_q[addr] <= res_wd[lpda_pkg::LANE_DECODER][lpda_pkg::SESS_W-1:0];
      res_e_q[addr] <= res_wd[lpda_pkg::LANE_ENCODER][lpda_pkg::SESS_W-1:0];
      res_l_q[addr] <= res_wd[lpda_pkg::LANE_LINK][lpda_pkg::LINK_W-1:0];
    end
    if (cmd_i.div) begin
      for (int k = 0; k < NL; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= {quo_q[k][Q_W-2:0], qbit[k]};
      end
    end
    if (cmd_i.cmp && better) begin
      best_q      <= idx_i;
      best_peak_q <= peak;
      best_sum_q  <= psum;
    end
    if (cmd_i.exec) begin
      res_dev_q <= (cmd_q == lpda_pkg::CMD_REGISTER && !refuse) ?
                   lpda_pkg::ID_W'(count_q) : '0;
      if (cmd_q == lpda_pkg::CMD_REGISTER) begin
        res_status_q <= refuse ? lpda_pkg::ST_REFUSED : lpda_pkg::ST_DONE;
      end else if (cmd_q == lpda_pkg::CMD_RELEASE) begin
        res_status_q <= id_ok ? lpda_pkg::ST_DONE : lpda_pkg::ST_BADID;
      end else begin
        res_status_q <= lpda_pkg::ST_DONE;
      end
    end
    if (cmd_i.apply) begin
      res_status_q <= found_q ? lpda_pkg::ST_DONE : lpda_pkg::ST_NOFIT;
      res_dev_q    <= found_q ? lpda_pkg::ID_W'(best_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_dev_q    <= res_dev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sealed_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (reg_we) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.begin_rsv) begin
        sealed_q <= 1'b1;
        found_q  <= 1'b0;
      end else if (cmd_i.cmp) begin
        found_q <= 1'b1;
      end
    end
  end

  assign stat_o.cmd   = cmd_q;
  assign stat_o.fit   = fit;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.last  = ((CNT_W'(idx_i) + CNT_W'(1)) == count_q);

  assign status_o        = out_status_q;
  assign chosen_device_o = out_dev_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DEVICES))
    else $error("device count beyond table size");

  a_seal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sealed_q |=> sealed_q)
    else $error("discovery seal cleared");

  a_no_reg_sealed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sealed_q |=> $stable(count_q))
    else $error("device registered after seal");

endmodule
